@@ hdl/tequ_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tequ_pkg
// Types and constants shared by the timed event queue and its list cells.
// ----------------------------------------------------------------------------
package tequ_pkg;

  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int CAR_KEY_BITS_DEF = 9;

  localparam int TIME_W   = 32;
  localparam int KIND_W   = 3;
  localparam int CAR_W    = 9;
  localparam int CLIENT_W = 17;
  localparam int OCC_W    = 7;

  // Input tdata layout: time, kind, car, client from bit 0 up, padded to 64.
  localparam int IN_TIME_LO   = 0;
  localparam int IN_KIND_LO   = IN_TIME_LO + TIME_W;
  localparam int IN_CAR_LO    = IN_KIND_LO + KIND_W;
  localparam int IN_CLIENT_LO = IN_CAR_LO + CAR_W;
  localparam int IN_BITS      = IN_CLIENT_LO + CLIENT_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout: popped event fields, then occupancy, padded to 72.
  localparam int OUT_OCC_LO = IN_BITS;
  localparam int OUT_BITS   = OUT_OCC_LO + OCC_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 3;

  localparam logic [TIME_W-1:0] TIME_INVALID = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // What every cell of the chain does at a clock edge.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_DELETE
  } cmd_t;

  // Event payload apart from the car key, whose width is a parameter.
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   ev_time;
  } ev_body_t;

  typedef struct packed {
    cmd_t     cmd;
    ev_body_t body;
  } cell_ctl_t;

endpackage

@@ hdl/timed_event_queue_keyed_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_keyed_update
// Bounded event list in ascending time order with insert, keyed update,
// keyed delete and pop, built as a shifting chain of list cells.
// ----------------------------------------------------------------------------
// The list is a row of QUEUE_DEPTH cells kept sorted by signed time, equal
// times in arrival order; every operation step moves all cells at once by
// at most one place. Insert, pop, delete and an ignored update are made of
// the accept and one chain step. An update of a car that holds m events
// removes them one per cycle and puts them back one per cycle, the last one
// once the output can take its result; when the car holds none it inserts
// the new event, or reports full when the list is full. A result is held in
// an output register, so the next transaction is accepted while it waits;
// the block only stalls when a new result is ready and the previous one has
// not been taken. Nothing needs clearing after reset.
// ----------------------------------------------------------------------------
module timed_event_queue_keyed_update #(
  parameter int QUEUE_DEPTH  = tequ_pkg::QUEUE_DEPTH_DEF,
  parameter int CAR_KEY_BITS = tequ_pkg::CAR_KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] event_time, [34:32] event_kind, [43:35] car_number,
  // [60:44] client_number, [63:61] zero
  input  logic [tequ_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [tequ_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] popped_time, [34:32] popped_kind, [43:35] popped_car,
  // [60:44] popped_client, [67:61] occupancy, [71:68] zero
  output logic [tequ_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status, [2] popped_valid
  output logic [tequ_pkg::OUT_USER_W-1:0] out_tuser
);
  import tequ_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_UPD_DEL,
    S_UPD_INS
  } state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r;
  ev_body_t                new_body_r;
  logic [CAR_KEY_BITS-1:0] new_car_r;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           copies_r, copies_nxt;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic                    out_pop_r;
  ev_body_t                out_body_r;
  logic [CAR_W-1:0]        out_car_r;
  logic [OCC_W-1:0]        out_occ_r;

  cell_ctl_t               ctl;
  logic                    res_load;
  status_t                 res_status;
  logic                    res_pop;

  logic                    valid_w [QUEUE_DEPTH];
  ev_body_t                body_w  [QUEUE_DEPTH];
  logic [CAR_KEY_BITS-1:0] car_w   [QUEUE_DEPTH];
  logic                    pos_w   [QUEUE_DEPTH];
  logic                    seen_w  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  valid_vec;

  logic in_accept;
  logic can_out;
  logic any_match;
  logic is_full;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign can_out   = !out_valid_r || out_tready;
  assign any_match = seen_w[QUEUE_DEPTH-1];
  assign is_full   = (count_r == COUNT_FULL);

  // ---------------------------------------------------------------- cell chain
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                    l_valid, r_valid, l_pos, l_seen;
    ev_body_t                l_body, r_body;
    logic [CAR_KEY_BITS-1:0] l_car, r_car;

    if (g == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_body  = '0;
      assign l_car   = '0;
      assign l_pos   = 1'b0;
      assign l_seen  = 1'b0;
    end else begin : g_left
      assign l_valid = valid_w[g-1];
      assign l_body  = body_w[g-1];
      assign l_car   = car_w[g-1];
      assign l_pos   = pos_w[g-1];
      assign l_seen  = seen_w[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_body  = '0;
      assign r_car   = '0;
    end else begin : g_right
      assign r_valid = valid_w[g+1];
      assign r_body  = body_w[g+1];
      assign r_car   = car_w[g+1];
    end

    tequ_cell #(
      .KEY_W(CAR_KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_car     (new_car_r),
      .left_valid  (l_valid),
      .left_body   (l_body),
      .left_car    (l_car),
      .left_pos    (l_pos),
      .left_seen   (l_seen),
      .right_valid (r_valid),
      .right_body  (r_body),
      .right_car   (r_car),
      .valid       (valid_w[g]),
      .body        (body_w[g]),
      .car         (car_w[g]),
      .pos         (pos_w[g]),
      .seen        (seen_w[g])
    );

    assign valid_vec[g] = valid_w[g];
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    copies_nxt = copies_r;
    ctl.cmd    = CMD_HOLD;
    ctl.body   = new_body_r;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_pop    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_UPDATE: begin
            if (new_body_r.ev_time == TIME_INVALID) begin
              if (can_out) begin
                res_load   = 1'b1;
                res_status = ST_IGNORED;
                state_nxt  = S_IDLE;
              end
            end else begin
              copies_nxt = '0;
              state_nxt  = S_UPD_DEL;
            end
          end
          OP_INSERT: begin
            if (can_out) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ctl.cmd   = CMD_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
          end
          OP_DELETE: begin
            if (can_out) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              ctl.cmd   = CMD_DELETE;
              if (any_match) begin
                count_nxt = count_r - CW'(1);
              end
            end
          end
          OP_POP: begin
            if (can_out) begin
              res_load  = 1'b1;
              state_nxt = S_IDLE;
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.cmd   = CMD_POP;
                res_pop   = 1'b1;
                count_nxt = count_r - CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_UPD_DEL: begin
        // Pull out every event of the car, counting them.
        if (any_match) begin
          ctl.cmd    = CMD_DELETE;
          count_nxt  = count_r - CW'(1);
          copies_nxt = copies_r + CW'(1);
        end else if (copies_r == '0) begin
          if (is_full) begin
            if (can_out) begin
              res_load   = 1'b1;
              res_status = ST_FULL;
              state_nxt  = S_IDLE;
            end
          end else begin
            copies_nxt = CW'(1);
            state_nxt  = S_UPD_INS;
          end
        end else begin
          state_nxt = S_UPD_INS;
        end
      end
      S_UPD_INS: begin
        // Put the rewritten copies back at the place of the new time.
        if (copies_r == CW'(1)) begin
          if (can_out) begin
            ctl.cmd   = CMD_INSERT;
            count_nxt = count_r + CW'(1);
            res_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl.cmd    = CMD_INSERT;
          count_nxt  = count_r + CW'(1);
          copies_nxt = copies_r - CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      copies_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      copies_r <= copies_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_accept) begin
      op_r               <= op_t'(in_tuser[1:0]);
      new_body_r.ev_time <= in_tdata[IN_TIME_LO +: TIME_W];
      new_body_r.kind    <= in_tdata[IN_KIND_LO +: KIND_W];
      new_body_r.client  <= in_tdata[IN_CLIENT_LO +: CLIENT_W];
      new_car_r          <= CAR_KEY_BITS'(in_tdata[IN_CAR_LO +: CAR_W]);
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_pop_r    <= res_pop;
      out_occ_r    <= OCC_W'(count_nxt);
      if (res_pop) begin
        out_body_r <= body_w[0];
        out_car_r  <= CAR_W'(car_w[0]);
      end else begin
        out_body_r <= '0;
        out_car_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_pop_r, out_status_r};
  assign out_tdata  = OUT_DATA_W'({out_occ_r, out_body_r.client, out_car_r,
                                   out_body_r.kind, out_body_r.ev_time});

  // ---------------------------------------------------------------- checks
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_vec)))
    else $error("event count differs from number of occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + QUEUE_DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied cells are not packed at the head of the chain");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (state_r != S_IDLE))
    else $error("result produced without a transaction in progress");

  for (genvar g = 0; g < QUEUE_DEPTH - 1; g++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (valid_w[g] && valid_w[g+1]) |->
        ($signed(body_w[g].ev_time) <= $signed(body_w[g+1].ev_time)))
      else $error("event list out of time order");
  end

endmodule

@@ hdl/tequ_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tequ_cell
// One slot of the ordered event list. It holds one event and, on each chain
// command, keeps it, takes the new event, or takes a neighbor's event.
// ----------------------------------------------------------------------------
module tequ_cell #(
  parameter int KEY_W = tequ_pkg::CAR_KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tequ_pkg::cell_ctl_t       ctl,
  input  logic [KEY_W-1:0]          new_car,
  input  logic                      left_valid,
  input  tequ_pkg::ev_body_t        left_body,
  input  logic [KEY_W-1:0]          left_car,
  input  logic                      left_pos,
  input  logic                      left_seen,
  input  logic                      right_valid,
  input  tequ_pkg::ev_body_t        right_body,
  input  logic [KEY_W-1:0]          right_car,
  output logic                      valid,
  output tequ_pkg::ev_body_t        body,
  output logic [KEY_W-1:0]          car,
  output logic                      pos,
  output logic                      seen
);
  import tequ_pkg::*;

  logic             valid_r, valid_nxt;
  ev_body_t         body_r, body_nxt;
  logic [KEY_W-1:0] car_r, car_nxt;

  // The list is sorted, so pos is low for a run of cells and then high:
  // the new event goes into the first cell whose pos is set.
  assign pos  = !valid_r || ($signed(body_r.ev_time) > $signed(ctl.body.ev_time));
  assign seen = left_seen || (valid_r && (car_r == new_car));

  assign valid = valid_r;
  assign body  = body_r;
  assign car   = car_r;

  always_comb begin
    valid_nxt = valid_r;
    body_nxt  = body_r;
    car_nxt   = car_r;
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (left_pos) begin
          valid_nxt = left_valid;
          body_nxt  = left_body;
          car_nxt   = left_car;
        end else if (pos) begin
          valid_nxt = 1'b1;
          body_nxt  = ctl.body;
          car_nxt   = new_car;
        end
      end
      CMD_POP: begin
        valid_nxt = right_valid;
        body_nxt  = right_body;
        car_nxt   = right_car;
      end
      CMD_DELETE: begin
        // Cells from the first match onward close the gap.
        if (seen) begin
          valid_nxt = right_valid;
          body_nxt  = right_body;
          car_nxt   = right_car;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    body_r <= body_nxt;
    car_r  <= car_nxt;
  end

endmodule

@@ dv/tb_timed_event_queue_keyed_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_queue_keyed_update
// Self-checking bench for the timed event queue. A directed opening covers
// empty and tie cases, signed times and keyed updates, then random traffic
// alternates fill, balanced and drain mixes so the list reaches both full and
// empty. A scoreboard keeps its own ordered copy of the list and checks every
// result field, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_timed_event_queue_keyed_update;
  import tequ_pkg::*;

  localparam int DEPTH          = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES   = 20_000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int LONG_HOLD      = 300;

  typedef enum int {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } traffic_mix_t;

  // Scoreboard: an ordered copy of the event list and the results it implies.
  class event_list_predictor;
    typedef struct packed {
      bit [TIME_W-1:0]   t;
      bit [KIND_W-1:0]   kind;
      bit [CAR_W-1:0]    car;
      bit [CLIENT_W-1:0] client;
    } sched_ev_t;

    typedef struct packed {
      status_t         status;
      bit              popped;
      sched_ev_t       ev;
      bit [OCC_W-1:0]  occ;
    } queue_result_t;

    sched_ev_t     held_events[$];
    queue_result_t expected_results[$];
    int errors, accepted, checked;
    int n_popped, n_full, n_empty, n_ignored, n_multi_update, peak_occ;

    // Equal times keep arrival order: new copies go after every equal time.
    function void place_ordered(sched_ev_t ev, int copies);
      int idx;
      idx = held_events.size();
      while (idx > 0 && $signed(held_events[idx-1].t) > $signed(ev.t)) idx--;
      repeat (copies) held_events.insert(idx, ev);
    endfunction

    function void note_accepted(op_t op, sched_ev_t ev);
      queue_result_t r;
      sched_ev_t kept[$];
      int hits;
      r = '0;
      r.status = ST_OK;
      accepted++;
      case (op)
        OP_INSERT: begin
          if (held_events.size() >= DEPTH) r.status = ST_FULL;
          else place_ordered(ev, 1);
        end
        OP_UPDATE: begin
          if (ev.t == TIME_INVALID) begin
            r.status = ST_IGNORED;
          end else begin
            hits = 0;
            foreach (held_events[i]) begin
              if (held_events[i].car == ev.car) hits++;
              else kept = {kept, held_events[i]};
            end
            held_events = kept;
            if (hits > 1) n_multi_update++;
            if (hits > 0) place_ordered(ev, hits);
            else if (held_events.size() >= DEPTH) r.status = ST_FULL;
            else place_ordered(ev, 1);
          end
        end
        OP_DELETE: begin
          for (int i = 0; i < held_events.size(); i++) begin
            if (held_events[i].car == ev.car) begin
              held_events.delete(i);
              break;
            end
          end
        end
        default: begin
          if (held_events.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.ev = held_events.pop_front();
            r.popped = 1'b1;
            n_popped++;
          end
        end
      endcase
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_EMPTY) n_empty++;
      if (r.status == ST_IGNORED) n_ignored++;
      r.occ = OCC_W'(held_events.size());
      if (held_events.size() > peak_occ) peak_occ = held_events.size();
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
                 $time, name, checked, want, got);
      end
    endfunction

    function void check_result(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no transaction pending: expected none, actual %0h_%0h",
                 $time, user, data);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("status", want.status, user[1:0]);
      compare_field("popped_valid", want.popped, user[2]);
      compare_field("popped_time", want.ev.t, data[IN_TIME_LO +: TIME_W]);
      compare_field("popped_kind", want.ev.kind, data[IN_KIND_LO +: KIND_W]);
      compare_field("popped_car", want.ev.car, data[IN_CAR_LO +: CAR_W]);
      compare_field("popped_client", want.ev.client, data[IN_CLIENT_LO +: CLIENT_W]);
      compare_field("occupancy", want.occ, data[OUT_OCC_LO +: OCC_W]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  event_list_predictor sb = new();
  bit sender_idles = 1'b1;

  timed_event_queue_keyed_update dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Both channels are observed at the rising edge; inputs change on the
  // falling edge, so the sampled values are settled.
  always @(posedge clk) begin
    event_list_predictor::sched_ev_t ev;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        ev.t      = in_tdata[IN_TIME_LO +: TIME_W];
        ev.kind   = in_tdata[IN_KIND_LO +: KIND_W];
        ev.car    = in_tdata[IN_CAR_LO +: CAR_W];
        ev.client = in_tdata[IN_CLIENT_LO +: CLIENT_W];
        sb.note_accepted(op_t'(in_tuser), ev);
      end
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_transaction(op_t op, bit [TIME_W-1:0] t, bit [KIND_W-1:0] kind,
                                  bit [CAR_W-1:0] car, bit [CLIENT_W-1:0] client);
    int gap;
    gap = sender_idles ? idle_cycles() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, client, car, kind, t};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // A handful of keys so updates and deletes usually find their car.
  function automatic bit [CAR_W-1:0] pick_car();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return 9'd255;
    if (r == 2) return CAR_W'($urandom_range(0, 255));
    return CAR_W'($urandom_range(0, 7));
  endfunction

  // Narrow ranges make equal times common, so tie order is exercised.
  function automatic bit [TIME_W-1:0] pick_time(bit for_update);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5 && for_update) return TIME_INVALID;
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return 32'h7FFF_FFFF;
        2: return TIME_INVALID;
        default: return 32'd1;
      endcase
    end
    if (r < 50) return $urandom_range(0, 15);
    if (r < 80) return $urandom_range(0, 5000);
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  task automatic send_random(traffic_mix_t mix);
    int r;
    op_t op;
    bit [CLIENT_W-1:0] client;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  op = (r < 50) ? OP_INSERT : (r < 75) ? OP_UPDATE : (r < 85) ? OP_DELETE : OP_POP;
      MIX_DRAIN: op = (r < 10) ? OP_INSERT : (r < 20) ? OP_UPDATE : (r < 35) ? OP_DELETE : OP_POP;
      default:   op = (r < 30) ? OP_INSERT : (r < 55) ? OP_UPDATE : (r < 70) ? OP_DELETE : OP_POP;
    endcase
    client = ($urandom_range(0, 9) == 0) ? '1 : CLIENT_W'($urandom_range(0, 65535));
    send_transaction(op, pick_time(op == OP_UPDATE), KIND_W'($urandom_range(0, 5)),
                     pick_car(), client);
  endtask

  // Receiver: ready bursts separated by random stalls, plus two long
  // hold-offs during which the sender keeps offering and the block backs up.
  initial begin
    int burst, stall, holds_done;
    out_tready = 1'b0;
    holds_done = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      out_tready <= 1'b1;
      repeat (burst) @(negedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      if ((holds_done == 0 && sb.checked >= 400) || (holds_done == 1 && sb.checked >= 1100)) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("%0t: run did not finish, %0d results outstanding",
             $time, sb.expected_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int remaining, seg, k, waited;
    traffic_mix_t mix;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_INSERT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: empty list, signed and tied times, keyed operations.
    send_transaction(OP_POP,    '0,           3'd0, 9'd0,   17'd0);
    send_transaction(OP_DELETE, '0,           3'd0, 9'd4,   17'd0);
    send_transaction(OP_UPDATE, TIME_INVALID, 3'd1, 9'd4,   17'd9);
    send_transaction(OP_INSERT, 32'd100,      3'd0, 9'd0,   17'd0);
    send_transaction(OP_INSERT, 32'd100,      3'd5, '1,     '1);
    send_transaction(OP_INSERT, 32'h7FFF_FFFF, 3'd3, 9'd255, 17'd65535);
    send_transaction(OP_INSERT, TIME_INVALID, 3'd1, 9'd1,   17'd1);
    send_transaction(OP_INSERT, 32'd0,        3'd2, 9'd3,   17'd30);
    send_transaction(OP_UPDATE, 32'd50,       3'd2, 9'd0,   17'd42);
    send_transaction(OP_UPDATE, 32'd10,       3'd4, 9'd9,   17'd7);
    send_transaction(OP_INSERT, 32'd100,      3'd0, 9'd3,   17'd31);
    // Car 3 now holds two events; both move together.
    send_transaction(OP_UPDATE, 32'd5,        3'd5, 9'd3,   17'd33);
    send_transaction(OP_UPDATE, TIME_INVALID, 3'd0, '1,     17'd0);
    send_transaction(OP_UPDATE, 32'd200,      3'd1, '1,     17'd2);
    send_transaction(OP_DELETE, '0,           3'd0, 9'd3,   17'd0);
    send_transaction(OP_DELETE, '0,           3'd0, 9'd77,  17'd0);
    repeat (4) send_transaction(OP_POP, '0, 3'd0, 9'd0, 17'd0);

    remaining = RANDOM_ITEMS;
    k = 0;
    while (remaining > 0) begin
      seg = $urandom_range(60, 200);
      if (seg > remaining) seg = remaining;
      case (k % 4)
        0: mix = MIX_FILL;
        2: mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      repeat (seg) send_random(mix);
      remaining -= seg;
      k++;
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (sb.expected_results.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions and %0d checked results; %0d events popped, peak %0d held.",
             sb.accepted, sb.checked, sb.n_popped, sb.peak_occ);
    $display("Full drops %0d, pops on empty %0d, ignored updates %0d, multi-event updates %0d.",
             sb.n_full, sb.n_empty, sb.n_ignored, sb.n_multi_update);
    if (sb.expected_results.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.expected_results.size());
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tequ_pkg.sv
hdl/tequ_cell.sv
hdl/timed_event_queue_keyed_update.sv
dv/tb_timed_event_queue_keyed_update.sv
